### rtl/hsvg_pkg.sv
package hsvg_pkg;

    // Field widths fixed by the interface
    localparam int KEY_BYTE_W     = 8;
    localparam int HASH_W         = 32;
    localparam int SEED_W         = 31;
    localparam int DIM_INDEX_W    = 9;
    localparam int DIM_VALUE_W    = 11;
    localparam int ACTIVE_TOTAL_W = 10;

    localparam int DIMENSIONS_DEF = 512;

    // Command and result codes
    localparam logic CMD_ABSORB = 1'b0;
    localparam logic CMD_DRAW   = 1'b1;
    localparam logic KIND_HASH  = 1'b0;
    localparam logic KIND_DRAW  = 1'b1;

    // FNV-1a, 32 bit
    localparam logic [HASH_W-1:0] FNV_BASIS = 32'd2166136261;
    localparam logic [HASH_W-1:0] FNV_PRIME = 32'd16777619;

    // LCG modulo 2^31
    localparam logic [SEED_W-1:0] LCG_MUL = 31'd1103515245;
    localparam logic [SEED_W-1:0] LCG_ADD = 31'd12345;

    // Exact reciprocals: floor(x/10) = (x*RECIP10)>>35 for x < 2^32,
    // floor(x/125) = (x*RECIP125)>>35 for x < 2^27
    localparam int                RECIP_SHIFT = 35;
    localparam logic [31:0]       RECIP10     = 32'hCCCC_CCCD;
    localparam logic [28:0]       RECIP125    = 29'h1062_4DD3;
    localparam int                Q10_W       = 28;
    localparam int                Q125_W      = 21;

    localparam logic [DIM_VALUE_W-1:0]        VAL_OFFSET = 11'd1000;
    localparam logic signed [DIM_VALUE_W-1:0] VAL_MIN    = -11'sd1000;
    localparam logic signed [DIM_VALUE_W-1:0] VAL_MAX    = 11'sd999;

    typedef struct packed {
        logic                          active;
        logic signed [DIM_VALUE_W-1:0] value;
    } dim_val_t;

endpackage

### rtl/hsvg_dimval.sv
// Finish seed mod 10 and seed mod 2000 from registered quotients.
module hsvg_dimval (
    input  logic [hsvg_pkg::SEED_W-1:0] seed,
    input  logic [hsvg_pkg::Q10_W-1:0]  q10,
    input  logic [hsvg_pkg::Q125_W-1:0] q2000,
    output hsvg_pkg::dim_val_t          dv
);

    logic [hsvg_pkg::SEED_W-1:0]      r10_full;
    logic [hsvg_pkg::SEED_W-1:0]      r2000_full;
    logic [hsvg_pkg::DIM_VALUE_W-1:0] r2000;

    // Remainders are small, so only low bits of the differences matter
    assign r10_full   = seed - (hsvg_pkg::SEED_W'(q10) * 31'd10);
    assign r2000_full = seed - (hsvg_pkg::SEED_W'(q2000) * 31'd2000);
    assign r2000      = r2000_full[hsvg_pkg::DIM_VALUE_W-1:0];

    always_comb begin
        dv.active = (r10_full[3:0] == 4'd0);
        dv.value  = '0;
        if (dv.active) begin
            dv.value = $signed(r2000 - hsvg_pkg::VAL_OFFSET);
        end
    end

endmodule

### rtl/hash_seeded_sparse_vector_gen_top.sv
// Seeded sparse vector generator. Key bytes (s_cmd = 0) fold into a
// 32-bit FNV-1a hash; the byte with s_final_byte set closes the key,
// returns one word carrying the hash (m_result_kind = 0), seeds a 31-bit
// LCG from the hash's low 31 bits and restarts the hash. Each draw
// (s_cmd = 1) steps the LCG and returns one dimension word: index,
// value in thousandths (-1000..999, zero when inactive), active flag,
// running active count and a last-dimension flag. Draws beyond
// DIMENSIONS-1 and non-final key bytes return nothing. The block takes
// one word per cycle while s_ready is high; a result word passes through
// stage 1, stage 2 and the output register before it is presented on the
// m_ ports. The path is: state update (one FNV and one LCG constant
// multiply) -> reciprocal multiplies for the mod-10 and mod-2000
// quotients -> remainder, value and active count into the output
// register. s_ready drops only when all three stages hold words and
// m_ready is low.
module hash_seeded_sparse_vector_gen_top #(
    parameter int DIMENSIONS = hsvg_pkg::DIMENSIONS_DEF
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     s_valid,
    output logic                                     s_ready,
    input  logic                                     s_cmd,
    input  logic [hsvg_pkg::KEY_BYTE_W-1:0]          s_key_byte,
    input  logic                                     s_final_byte,
    output logic                                     m_valid,
    input  logic                                     m_ready,
    output logic                                     m_result_kind,
    output logic [hsvg_pkg::HASH_W-1:0]              m_hash_signature,
    output logic [hsvg_pkg::DIM_INDEX_W-1:0]         m_dim_index,
    output logic signed [hsvg_pkg::DIM_VALUE_W-1:0]  m_dim_value,
    output logic                                     m_dim_active,
    output logic [hsvg_pkg::ACTIVE_TOTAL_W-1:0]      m_active_total,
    output logic                                     m_vector_done
);

    localparam int CNT_W = $clog2(DIMENSIONS + 1);
    localparam int HW    = hsvg_pkg::HASH_W;
    localparam int SW    = hsvg_pkg::SEED_W;
    localparam int IW    = hsvg_pkg::DIM_INDEX_W;
    localparam int AW    = hsvg_pkg::ACTIVE_TOTAL_W;

    // ------------------------------------------------------------------
    // Architectural state
    // ------------------------------------------------------------------
    logic [HW-1:0]    hash_reg, hash_next;
    logic [HW-1:0]    sig_reg, sig_next;
    logic [SW-1:0]    seed_reg, seed_next;
    logic [CNT_W-1:0] dim_cnt_reg, dim_cnt_next;
    logic [AW-1:0]    act_cnt_reg, act_cnt_next;

    // Stage 1: word after the state update
    logic          v1_reg;
    logic          k1_reg;
    logic [HW-1:0] h1_reg;
    logic [IW-1:0] i1_reg;
    logic          d1_reg;
    logic [SW-1:0] s1_reg;

    // Stage 2: word with quotients
    logic                          v2_reg;
    logic                          k2_reg;
    logic [HW-1:0]                 h2_reg;
    logic [IW-1:0]                 i2_reg;
    logic                          d2_reg;
    logic [SW-1:0]                 s2_reg;
    logic [hsvg_pkg::Q10_W-1:0]    q10_reg;
    logic [hsvg_pkg::Q125_W-1:0]   q2000_reg;

    // Output register
    logic                                    v3_reg;
    logic                                    k3_reg;
    logic [HW-1:0]                           h3_reg;
    logic [IW-1:0]                           i3_reg;
    logic signed [hsvg_pkg::DIM_VALUE_W-1:0] val3_reg;
    logic                                    act3_reg;
    logic [AW-1:0]                           tot3_reg;
    logic                                    d3_reg;

    logic rdy1, rdy2, rdy3;
    logic accept;
    logic emit;
    logic emit_kind;
    logic draw_ok;
    logic [HW-1:0]  fold;
    logic [SW-1:0]  lcg;
    logic [IW-1:0]  idx_w;
    logic [62:0]    prod10;
    logic [55:0]    prod2000;
    hsvg_pkg::dim_val_t dv;

    // Each stage moves when the one after it has room
    assign rdy3    = !v3_reg || m_ready;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1;
    assign accept  = s_valid && s_ready;

    assign fold    = (hash_reg ^ HW'(s_key_byte)) * hsvg_pkg::FNV_PRIME;
    assign lcg     = (seed_reg * hsvg_pkg::LCG_MUL) + hsvg_pkg::LCG_ADD;
    assign draw_ok = (dim_cnt_reg < CNT_W'(DIMENSIONS));

    generate
        if (CNT_W >= IW) begin : g_idx_trunc
            assign idx_w = dim_cnt_reg[IW-1:0];
        end else begin : g_idx_ext
            assign idx_w = {{(IW - CNT_W){1'b0}}, dim_cnt_reg};
        end
    endgenerate

    // ------------------------------------------------------------------
    // State update for the accepted word
    // ------------------------------------------------------------------
    always_comb begin
        hash_next    = hash_reg;
        sig_next     = sig_reg;
        seed_next    = seed_reg;
        dim_cnt_next = dim_cnt_reg;
        emit         = 1'b0;
        emit_kind    = hsvg_pkg::KIND_HASH;
        if (accept) begin
            if (s_cmd == hsvg_pkg::CMD_ABSORB) begin
                if (s_final_byte) begin
                    // close the key: latch signature, reseed, restart hash
                    sig_next     = fold;
                    seed_next    = fold[SW-1:0];
                    dim_cnt_next = '0;
                    hash_next    = hsvg_pkg::FNV_BASIS;
                    emit         = 1'b1;
                    emit_kind    = hsvg_pkg::KIND_HASH;
                end else begin
                    hash_next = fold;
                end
            end else if (draw_ok) begin
                seed_next    = lcg;
                dim_cnt_next = dim_cnt_reg + CNT_W'(1);
                emit         = 1'b1;
                emit_kind    = hsvg_pkg::KIND_DRAW;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg    <= hsvg_pkg::FNV_BASIS;
            sig_reg     <= '0;
            seed_reg    <= '0;
            dim_cnt_reg <= '0;
        end else begin
            hash_reg    <= hash_next;
            sig_reg     <= sig_next;
            seed_reg    <= seed_next;
            dim_cnt_reg <= dim_cnt_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: capture the word that produces a result
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (rdy1) begin
            v1_reg <= emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && emit) begin
            k1_reg <= emit_kind;
            h1_reg <= (emit_kind == hsvg_pkg::KIND_HASH) ? fold : sig_reg;
            i1_reg <= idx_w;
            d1_reg <= (emit_kind == hsvg_pkg::KIND_DRAW) &&
                      (dim_cnt_reg == CNT_W'(DIMENSIONS - 1));
            s1_reg <= lcg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: reciprocal multiplies for seed/10 and seed/2000
    // ------------------------------------------------------------------
    assign prod10   = 63'(s1_reg) * 63'(hsvg_pkg::RECIP10);
    assign prod2000 = 56'(s1_reg[SW-1:4]) * 56'(hsvg_pkg::RECIP125);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (rdy2) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy2 && v1_reg) begin
            k2_reg    <= k1_reg;
            h2_reg    <= h1_reg;
            i2_reg    <= i1_reg;
            d2_reg    <= d1_reg;
            s2_reg    <= s1_reg;
            q10_reg   <= prod10[hsvg_pkg::RECIP_SHIFT +: hsvg_pkg::Q10_W];
            q2000_reg <= prod2000[hsvg_pkg::RECIP_SHIFT +: hsvg_pkg::Q125_W];
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: remainders, value and running active count
    // ------------------------------------------------------------------
    hsvg_dimval u_dimval (
        .seed  (s2_reg),
        .q10   (q10_reg),
        .q2000 (q2000_reg),
        .dv    (dv)
    );

    always_comb begin
        act_cnt_next = act_cnt_reg;
        if (rdy3 && v2_reg) begin
            if (k2_reg == hsvg_pkg::KIND_HASH) begin
                act_cnt_next = '0;
            end else if (dv.active) begin
                act_cnt_next = act_cnt_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg      <= 1'b0;
            act_cnt_reg <= '0;
        end else begin
            act_cnt_reg <= act_cnt_next;
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy3 && v2_reg) begin
            k3_reg <= k2_reg;
            h3_reg <= h2_reg;
            if (k2_reg == hsvg_pkg::KIND_HASH) begin
                // hash word: dimension fields read as zero
                i3_reg   <= '0;
                val3_reg <= '0;
                act3_reg <= 1'b0;
                tot3_reg <= '0;
                d3_reg   <= 1'b0;
            end else begin
                i3_reg   <= i2_reg;
                val3_reg <= dv.value;
                act3_reg <= dv.active;
                tot3_reg <= act_cnt_next;
                d3_reg   <= d2_reg;
            end
        end
    end

    assign m_valid          = v3_reg;
    assign m_result_kind    = k3_reg;
    assign m_hash_signature = h3_reg;
    assign m_dim_index      = i3_reg;
    assign m_dim_value      = val3_reg;
    assign m_dim_active     = act3_reg;
    assign m_active_total   = tot3_reg;
    assign m_vector_done    = d3_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_final_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (s_cmd == hsvg_pkg::CMD_ABSORB) && s_final_byte |=>
            (hash_reg == hsvg_pkg::FNV_BASIS) && (dim_cnt_reg == '0))
        else $error("final byte did not restart hash and dimension count");

    a_hash_word_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_result_kind == hsvg_pkg::KIND_HASH) |->
            (m_dim_index == '0) && (m_dim_value == '0) && !m_dim_active &&
            (m_active_total == '0) && !m_vector_done)
        else $error("hash word carries dimension fields");

    a_inactive_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_dim_active |-> (m_dim_value == '0))
        else $error("inactive dimension with nonzero value");

    a_value_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_dim_active |->
            (m_dim_value >= hsvg_pkg::VAL_MIN) && (m_dim_value <= hsvg_pkg::VAL_MAX))
        else $error("dimension value out of range");

    a_dim_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        dim_cnt_reg <= CNT_W'(DIMENSIONS))
        else $error("dimension count past the vector length");

endmodule
